// File: design/mswd_pkg.sv
// shared types, request codes, register indexes and reset values for the
// multi-worker stall watchdog; no dependencies
`default_nettype none

package mswd_pkg;

	localparam int NUM_WORKERS      = 8;
	localparam int TICK_COUNT_WIDTH = 32;
	localparam int SLOT_W           = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int LIMIT_W          = 32;
	localparam int CMP_W            = (TICK_COUNT_WIDTH > LIMIT_W) ? TICK_COUNT_WIDTH : LIMIT_W;
	localparam int INTERVAL_W       = 16;

	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_REGISTER  = 3'd1;
	localparam logic [2:0] REQ_RELEASE   = 3'd2;
	localparam logic [2:0] REQ_HEARTBEAT = 3'd3;
	localparam logic [2:0] REQ_INACTIVE  = 3'd4;
	localparam logic [2:0] REQ_QUEUE     = 3'd5;

	localparam int         CFG_IDX_W        = 1;
	localparam logic [0:0] CFG_STALL_LIMIT  = 1'b0;
	localparam logic [0:0] CFG_MON_INTERVAL = 1'b1;

	localparam logic [LIMIT_W-1:0]    STALL_LIMIT_RST  = 32'd3000;
	localparam logic [INTERVAL_W-1:0] MON_INTERVAL_RST = 16'd250;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  worker_slot;
		logic [15:0] queue_size;
	} req_t;

	typedef struct packed {
		logic [2:0] restart_slot;
		logic       last_restart;
	} rsp_t;

	// control from the sequencer to the slot registers
	typedef struct packed {
		logic              cmd_en;
		logic [2:0]        cmd;
		logic [SLOT_W-1:0] cmd_slot;
		logic              step_en;
		logic [SLOT_W-1:0] step_idx;
		logic              hit;
	} slot_op_t;

	// flags of the slot under the walk pointer
	typedef struct packed {
		logic used;
		logic active;
		logic latched;
	} slot_view_t;

endpackage

`default_nettype wire

// File: design/mswd_slot_regs.sv
// per-slot state: in-use, active, restart latch and tick count
// depends on mswd_pkg
`default_nettype none

module mswd_slot_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mswd_pkg::slot_op_t                   op,
	input  wire logic [mswd_pkg::TICK_COUNT_WIDTH-1:0] cnt_nxt,
	output mswd_pkg::slot_view_t                      view,
	output logic [mswd_pkg::TICK_COUNT_WIDTH-1:0]     cnt_rd,
	output logic                                      any_used
);

	logic [mswd_pkg::NUM_WORKERS-1:0]      used_q;
	logic [mswd_pkg::NUM_WORKERS-1:0]      active_q;
	logic [mswd_pkg::NUM_WORKERS-1:0]      latched_q;
	logic [mswd_pkg::TICK_COUNT_WIDTH-1:0] count_q [mswd_pkg::NUM_WORKERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			active_q  <= '0;
			latched_q <= '0;
			for (int i = 0; i < mswd_pkg::NUM_WORKERS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (op.cmd_en) begin
				case (op.cmd)
					mswd_pkg::REQ_REGISTER: begin
						used_q[op.cmd_slot]    <= 1'b1;
						active_q[op.cmd_slot]  <= 1'b1;
						latched_q[op.cmd_slot] <= 1'b0;
						count_q[op.cmd_slot]   <= '0;
					end
					mswd_pkg::REQ_RELEASE: begin
						used_q[op.cmd_slot]    <= 1'b0;
						active_q[op.cmd_slot]  <= 1'b0;
						latched_q[op.cmd_slot] <= 1'b0;
						count_q[op.cmd_slot]   <= '0;
					end
					mswd_pkg::REQ_HEARTBEAT: begin
						if (used_q[op.cmd_slot]) begin
							active_q[op.cmd_slot] <= 1'b1;
							count_q[op.cmd_slot]  <= '0;
						end
					end
					mswd_pkg::REQ_INACTIVE: begin
						if (used_q[op.cmd_slot]) begin
							active_q[op.cmd_slot] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (op.step_en) begin
				count_q[op.step_idx] <= cnt_nxt;
				if (op.hit) begin
					latched_q[op.step_idx] <= 1'b1;
					active_q[op.step_idx]  <= 1'b0;
				end
			end
		end
	end

	assign view.used    = used_q[op.step_idx];
	assign view.active  = active_q[op.step_idx];
	assign view.latched = latched_q[op.step_idx];
	assign cnt_rd       = count_q[op.step_idx];
	assign any_used     = |used_q;

endmodule

`default_nettype wire

// File: design/mswd_step_unit.sv
// shared unit: saturating count increment and stall-limit compare for one slot
// depends on mswd_pkg
`default_nettype none

module mswd_step_unit (
	input  wire logic [mswd_pkg::TICK_COUNT_WIDTH-1:0] cnt_rd,
	input  wire mswd_pkg::slot_view_t                  view,
	input  wire logic [mswd_pkg::LIMIT_W-1:0]          stall_limit,
	input  wire logic                                  check_en,
	output logic [mswd_pkg::TICK_COUNT_WIDTH-1:0]      cnt_nxt,
	output logic                                       hit
);

	logic over;

	always_comb begin
		cnt_nxt = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
		over    = mswd_pkg::CMP_W'(cnt_nxt) > mswd_pkg::CMP_W'(stall_limit);
		hit     = check_en && view.used && view.active && !view.latched && over;
	end

endmodule

`default_nettype wire

// File: design/multi_worker_stall_watchdog.sv
// top level of the multi-worker stall watchdog: sequencer, config registers
// depends on mswd_pkg, mswd_slot_regs, mswd_step_unit
//
//  port group   | signals                        | handshake
//  -------------+--------------------------------+-------------------------------
//  request      | start, busy, req               | taken when start & !busy
//  result       | rsp_valid, rsp                 | one-cycle strobe, no stall
//  config       | cfg_we, cfg_index, cfg_wdata   | written when cfg_we is high
//
// non-tick requests finish in the cycle they are taken; busy stays low
// a tick holds busy through the walk and flush states: one slot per cycle goes through
// the shared increment/compare unit, then the flush state emits the held result
// a restart word is held until the next hit or the flush state, then registered;
// the final word of a check shows in the first cycle after busy drops
// reset clears every slot, the interval counter and the pending flag at once
`default_nettype none

module multi_worker_stall_watchdog (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire mswd_pkg::req_t                     req,
	output logic                                    rsp_valid,
	output mswd_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_we,
	input  wire logic [mswd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mswd_pkg::LIMIT_W-1:0]       cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t                              state_q;
	logic [mswd_pkg::SLOT_W-1:0]         idx_q;
	logic [mswd_pkg::SLOT_W-1:0]         pend_slot_q;
	logic                                pend_v_q;
	logic                                check_en_q;
	logic                                work_pending_q;
	logic [mswd_pkg::INTERVAL_W-1:0]     interval_q;
	logic [mswd_pkg::LIMIT_W-1:0]        stall_limit_q;
	logic [mswd_pkg::INTERVAL_W-1:0]     mon_interval_q;
	logic                                rsp_valid_q;
	mswd_pkg::rsp_t                      rsp_q;

	mswd_pkg::slot_op_t                      op;
	mswd_pkg::slot_view_t                    view;
	logic [mswd_pkg::TICK_COUNT_WIDTH-1:0]   cnt_rd;
	logic [mswd_pkg::TICK_COUNT_WIDTH-1:0]   cnt_nxt;
	logic                                    hit;
	logic                                    any_used;
	logic                                    take;
	logic                                    slot_ok;
	logic [mswd_pkg::INTERVAL_W-1:0]         interval_nxt;
	logic                                    due;

	assign take    = start && (state_q == ST_IDLE);
	assign slot_ok = int'(req.worker_slot) < mswd_pkg::NUM_WORKERS;

	always_comb begin
		interval_nxt = (&interval_q) ? interval_q : interval_q + 1'b1;
		due          = interval_nxt >= mon_interval_q;

		op.cmd_en   = take && (req.req_type != mswd_pkg::REQ_TICK) && slot_ok;
		op.cmd      = req.req_type;
		op.cmd_slot = mswd_pkg::SLOT_W'(req.worker_slot);
		op.step_en  = (state_q == ST_WALK);
		op.step_idx = idx_q;
		op.hit      = hit;
	end

	mswd_slot_regs u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.cnt_nxt  (cnt_nxt),
		.view     (view),
		.cnt_rd   (cnt_rd),
		.any_used (any_used)
	);

	mswd_step_unit u_step (
		.cnt_rd      (cnt_rd),
		.view        (view),
		.stall_limit (stall_limit_q),
		.check_en    (check_en_q),
		.cnt_nxt     (cnt_nxt),
		.hit         (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q  <= mswd_pkg::STALL_LIMIT_RST;
			mon_interval_q <= mswd_pkg::MON_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mswd_pkg::CFG_STALL_LIMIT:  stall_limit_q  <= cfg_wdata;
				mswd_pkg::CFG_MON_INTERVAL: mon_interval_q <= cfg_wdata[mswd_pkg::INTERVAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			pend_slot_q    <= '0;
			pend_v_q       <= 1'b0;
			check_en_q     <= 1'b0;
			work_pending_q <= 1'b0;
			interval_q     <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rsp_valid_q <= 1'b0;
					if (take) begin
						case (req.req_type)
							mswd_pkg::REQ_TICK: begin
								interval_q <= due ? '0 : interval_nxt;
								check_en_q <= due && work_pending_q && any_used;
								idx_q      <= '0;
								pend_v_q   <= 1'b0;
								state_q    <= ST_WALK;
							end
							mswd_pkg::REQ_QUEUE: begin
								work_pending_q <= |req.queue_size;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					// hold each restart until the next hit or the flush so the final word can be flagged
					rsp_valid_q <= hit && pend_v_q;
					if (hit) begin
						if (pend_v_q) begin
							rsp_q.restart_slot  <= 3'(pend_slot_q);
							rsp_q.last_restart  <= 1'b0;
						end
						pend_slot_q <= idx_q;
						pend_v_q    <= 1'b1;
					end
					if (idx_q == mswd_pkg::SLOT_W'(mswd_pkg::NUM_WORKERS - 1)) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					rsp_valid_q <= pend_v_q;
					if (pend_v_q) begin
						rsp_q.restart_slot <= 3'(pend_slot_q);
						rsp_q.last_restart <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					rsp_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: design/mswd_checker.sv
// port-level checks for the multi-worker stall watchdog, bound to the top level
// depends on mswd_pkg and multi_worker_stall_watchdog
`default_nettype none

module mswd_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire mswd_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire mswd_pkg::rsp_t rsp
);

	// a tick always starts a slot walk
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == mswd_pkg::REQ_TICK |=> busy)
		else $error("tick taken but block not busy");

	// other requests complete in the cycle they are taken
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type != mswd_pkg::REQ_TICK |=> !busy)
		else $error("non-tick request left block busy");

	// restart words only come out of a walk
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy))
		else $error("restart word outside of a check");

	// the final word of a check is not followed by another at once
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last_restart |=> !rsp_valid)
		else $error("word right after final restart");

endmodule

bind multi_worker_stall_watchdog mswd_checker u_mswd_checker (.*);

`default_nettype wire
